// File: src/afsk_hdlc_nrzi_modulator_top_defines.svh
// assertion macros used by the checker file afsk_chk.sv
`ifndef AFSK_HDLC_NRZI_MODULATOR_TOP_DEFINES_SVH
`define AFSK_HDLC_NRZI_MODULATOR_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define AFSK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFSK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/afsk_pkg.sv
`timescale 1ns / 1ps

package afsk_pkg;

    localparam int unsigned ROM_INDEX_BITS = 8;
    localparam int unsigned ROM_DEPTH      = 1 << ROM_INDEX_BITS;
    localparam int unsigned APB_ADDR_BITS  = 5;

    localparam logic [7:0] HDLC_FLAG   = 8'h7E;
    localparam logic [2:0] STUFF_LIMIT = 3'd5;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        REG_SPACE_STEP      = 3'd0,
        REG_MARK_STEP       = 3'd1,
        REG_SAMPLES_PER_BIT = 3'd2,
        REG_PREAMBLE_FLAGS  = 3'd3,
        REG_MAX_PACKETS     = 3'd4
    } reg_idx_t;

    localparam logic [31:0] SPACE_STEP_RST      = 32'd984263338;
    localparam logic [31:0] MARK_STEP_RST       = 32'd536870912;
    localparam logic [7:0]  SAMPLES_PER_BIT_RST = 8'd8;
    localparam logic [7:0]  PREAMBLE_FLAGS_RST  = 8'd23;
    localparam logic [3:0]  MAX_PACKETS_RST     = 4'd3;
    localparam logic [7:0]  SAMPLE_MID          = 8'd128;

    // unsigned sine, midpoint 128
    localparam logic [7:0] SINE_ROM [ROM_DEPTH] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
        8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
        8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
        8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
        8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
        8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
        8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
        8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// File: src/afsk_if.sv
`timescale 1ns / 1ps

interface afsk_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       byte_is_flag;
    logic       last_in_packet;

    modport source (
        output valid, opcode, data_byte, data_valid, byte_is_flag, last_in_packet,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, data_valid, byte_is_flag, last_in_packet,
        output ready
    );
endinterface

interface afsk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       take_byte;
    logic       active;
    logic       tone;

    modport source (
        output valid, sample, take_byte, active, tone,
        input  ready
    );
    modport sink (
        input  valid, sample, take_byte, active, tone,
        output ready
    );
endinterface

// File: src/afsk_hdlc_nrzi_modulator_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// in_ch     in   valid/ready   opcode, data_byte, data_valid, byte_is_flag, last_in_packet
// out_ch    out  valid/ready   sample, take_byte, active, tone
// apb       in   psel/penable  paddr, pwdata, prdata (pready tied high)
//
// one beat per clock unless out_ch stalls: the whole tick (bit clock, byte load,
// stuffing, nrzi, phase add and sine lookup) sits between the state registers
// and the result register, so every in beat leaves its result in the next cycle
// in_ch.ready stays high while the result register is empty or being taken
// rst_n is asynchronous; all state and config return to their reset values

module afsk_hdlc_nrzi_modulator_top
    import afsk_pkg::*;
#(
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    afsk_in_if.sink                  in_ch,
    afsk_out_if.source               out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // config registers
    logic [31:0] space_step_reg;
    logic [31:0] mark_step_reg;
    logic [7:0]  samples_per_bit_reg;
    logic [7:0]  preamble_flags_reg;
    logic [3:0]  max_packets_reg;

    // modulator state
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic                  tone_sel_reg, tone_sel_next;
    logic [7:0]            tick_in_bit_reg, tick_in_bit_next;
    logic [2:0]            bit_in_byte_reg, bit_in_byte_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [2:0]            ones_run_reg, ones_run_next;
    logic                  unstuffed_mode_reg, unstuffed_mode_next;
    logic [7:0]            preamble_left_reg, preamble_left_next;
    logic [3:0]            packets_left_reg, packets_left_next;
    logic                  in_packet_reg, in_packet_next;
    logic                  closing_flag_due_reg, closing_flag_due_next;
    logic                  sending_reg, sending_next;
    logic [7:0]            last_sample_reg, last_sample_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic take_byte_reg, take_byte_next;

    logic                  in_accept;
    logic                  cfg_write;
    reg_idx_t              reg_idx;
    logic                  stop;
    logic                  cur_bit;
    logic [7:0]            next_tick;
    logic [PHASE_BITS-1:0] step;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_SPACE_STEP:      prdata = space_step_reg;
            REG_MARK_STEP:       prdata = mark_step_reg;
            REG_SAMPLES_PER_BIT: prdata = {24'd0, samples_per_bit_reg};
            REG_PREAMBLE_FLAGS:  prdata = {24'd0, preamble_flags_reg};
            REG_MAX_PACKETS:     prdata = {28'd0, max_packets_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_step_reg      <= SPACE_STEP_RST;
            mark_step_reg       <= MARK_STEP_RST;
            samples_per_bit_reg <= SAMPLES_PER_BIT_RST;
            preamble_flags_reg  <= PREAMBLE_FLAGS_RST;
            max_packets_reg     <= MAX_PACKETS_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SPACE_STEP:      space_step_reg      <= pwdata;
                REG_MARK_STEP:       mark_step_reg       <= pwdata;
                REG_SAMPLES_PER_BIT: samples_per_bit_reg <= pwdata[7:0];
                REG_PREAMBLE_FLAGS:  preamble_flags_reg  <= pwdata[7:0];
                REG_MAX_PACKETS:     max_packets_reg     <= pwdata[3:0];
                default:             ;
            endcase
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        phase_acc_next        = phase_acc_reg;
        tone_sel_next         = tone_sel_reg;
        tick_in_bit_next      = tick_in_bit_reg;
        bit_in_byte_next      = bit_in_byte_reg;
        shift_byte_next       = shift_byte_reg;
        ones_run_next         = ones_run_reg;
        unstuffed_mode_next   = unstuffed_mode_reg;
        preamble_left_next    = preamble_left_reg;
        packets_left_next     = packets_left_reg;
        in_packet_next        = in_packet_reg;
        closing_flag_due_next = closing_flag_due_reg;
        sending_next          = sending_reg;
        last_sample_next      = last_sample_reg;
        take_byte_next        = take_byte_reg;
        out_valid_next        = out_valid_reg && !out_ch.ready;
        stop                  = 1'b0;
        cur_bit               = 1'b0;
        next_tick             = tick_in_bit_reg + 8'd1;
        step                  = tone_sel_reg ? mark_step_reg[PHASE_BITS-1:0]
                                             : space_step_reg[PHASE_BITS-1:0];

        if (in_accept)
        begin
            out_valid_next = 1'b1;
            take_byte_next = 1'b0;
            if (in_ch.opcode == OP_START)
            begin
                // a start while sending is ignored
                if (!sending_reg)
                begin
                    phase_acc_next        = '0;
                    ones_run_next         = '0;
                    bit_in_byte_next      = '0;
                    tick_in_bit_next      = '0;
                    preamble_left_next    = preamble_flags_reg;
                    unstuffed_mode_next   = 1'b1;
                    in_packet_next        = 1'b0;
                    closing_flag_due_next = 1'b0;
                    packets_left_next     = max_packets_reg;
                    sending_next          = 1'b1;
                end
            end
            else if (sending_reg)
            begin
                if (tick_in_bit_reg == 8'd0)
                begin
                    if (bit_in_byte_reg == 3'd0)
                    begin
                        priority if (preamble_left_reg != 8'd0)
                        begin
                            shift_byte_next    = HDLC_FLAG;
                            preamble_left_next = preamble_left_reg - 8'd1;
                        end
                        else if (in_packet_reg && closing_flag_due_reg)
                        begin
                            shift_byte_next       = HDLC_FLAG;
                            unstuffed_mode_next   = 1'b1;
                            closing_flag_due_next = 1'b0;
                            in_packet_next        = 1'b0;
                        end
                        else
                        begin
                            if (!in_packet_reg)
                            begin
                                if (packets_left_reg == 4'd0)
                                    stop = 1'b1;
                                else
                                    packets_left_next = packets_left_reg - 4'd1;
                            end
                            // the packet count stays spent on an underrun
                            if (!stop)
                            begin
                                if (!in_ch.data_valid)
                                    stop = 1'b1;
                                else
                                begin
                                    in_packet_next        = 1'b1;
                                    shift_byte_next       = in_ch.data_byte;
                                    unstuffed_mode_next   = in_ch.byte_is_flag;
                                    closing_flag_due_next = in_ch.last_in_packet;
                                    take_byte_next        = 1'b1;
                                end
                            end
                        end
                    end

                    if (!stop)
                    begin
                        // stuffed zero holds the shift register and bit count
                        if (ones_run_reg == STUFF_LIMIT)
                            cur_bit = 1'b0;
                        else
                        begin
                            cur_bit          = shift_byte_next[0];
                            shift_byte_next  = {1'b0, shift_byte_next[7:1]};
                            bit_in_byte_next = bit_in_byte_reg + 3'd1;
                        end
                        if (!cur_bit || unstuffed_mode_next)
                            ones_run_next = '0;
                        else
                            ones_run_next = ones_run_reg + 3'd1;
                        if (!cur_bit)
                        begin
                            tone_sel_next = !tone_sel_reg;
                            step = tone_sel_reg ? space_step_reg[PHASE_BITS-1:0]
                                                : mark_step_reg[PHASE_BITS-1:0];
                        end
                    end
                end

                if (stop)
                    sending_next = 1'b0;
                else
                begin
                    tick_in_bit_next = (next_tick >= samples_per_bit_reg) ? 8'd0 : next_tick;
                    phase_acc_next   = phase_acc_reg + step;
                    last_sample_next =
                        SINE_ROM[phase_acc_next[PHASE_BITS-1 -: ROM_INDEX_BITS]];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg        <= '0;
            tone_sel_reg         <= 1'b0;
            tick_in_bit_reg      <= '0;
            bit_in_byte_reg      <= '0;
            shift_byte_reg       <= '0;
            ones_run_reg         <= '0;
            unstuffed_mode_reg   <= 1'b1;
            preamble_left_reg    <= '0;
            packets_left_reg     <= '0;
            in_packet_reg        <= 1'b0;
            closing_flag_due_reg <= 1'b0;
            sending_reg          <= 1'b0;
            last_sample_reg      <= SAMPLE_MID;
            out_valid_reg        <= 1'b0;
            take_byte_reg        <= 1'b0;
        end
        else
        begin
            phase_acc_reg        <= phase_acc_next;
            tone_sel_reg         <= tone_sel_next;
            tick_in_bit_reg      <= tick_in_bit_next;
            bit_in_byte_reg      <= bit_in_byte_next;
            shift_byte_reg       <= shift_byte_next;
            ones_run_reg         <= ones_run_next;
            unstuffed_mode_reg   <= unstuffed_mode_next;
            preamble_left_reg    <= preamble_left_next;
            packets_left_reg     <= packets_left_next;
            in_packet_reg        <= in_packet_next;
            closing_flag_due_reg <= closing_flag_due_next;
            sending_reg          <= sending_next;
            last_sample_reg      <= last_sample_next;
            out_valid_reg        <= out_valid_next;
            take_byte_reg        <= take_byte_next;
        end
    end

    // the result beat shows the state left by its tick
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.sample    = last_sample_reg;
    assign out_ch.take_byte = take_byte_reg;
    assign out_ch.active    = sending_reg;
    assign out_ch.tone      = tone_sel_reg;

endmodule

// File: src/afsk_chk.sv
`timescale 1ns / 1ps
`include "afsk_hdlc_nrzi_modulator_top_defines.svh"

module afsk_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] sample,
    input logic       take_byte,
    input logic       active,
    input logic       tone
);

    // every in beat leaves a result in the next cycle
    `AFSK_ASSERT_NXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "no result after in beat")

    // an empty result register never blocks the input
    `AFSK_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input blocked while output empty")

    // a byte is only consumed by a tick that keeps transmitting
    `AFSK_ASSERT_IMP(a_take_needs_active, clk, rst_n, out_valid && take_byte, active, "byte taken while stopped")

    // stalled result beat holds
    `AFSK_ASSERT_NXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(take_byte) && $stable(active) && $stable(tone), "stalled result changed")

endmodule

bind afsk_hdlc_nrzi_modulator_top afsk_chk u_afsk_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sample    (out_ch.sample),
    .take_byte (out_ch.take_byte),
    .active    (out_ch.active),
    .tone      (out_ch.tone)
);
